/* src/kpcalc_pkg.sv */
// Shared types and key codes for the keypad calculator.
`default_nettype none

package kpcalc_pkg;

   localparam int DATA_W    = 16;
   localparam int CMD_W     = 3;
   localparam int DIGIT_W   = 4;
   localparam int DIV_STEPS = DATA_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // key codes; a pending operator uses the same codes, with OP_NONE for none
   localparam logic [CMD_W-1:0] CMD_DIGIT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SUB    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MUL    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DIV    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_EQUALS = 3'd5;
   localparam logic [CMD_W-1:0] OP_NONE    = 3'd0;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [DIGIT_W-1:0] digit;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              div_error;
   } rsp_type;

endpackage

`default_nettype wire

/* src/keypad_left_to_right_calculator_top.sv */
// Keypad calculator: one key per request, left-to-right evaluation, one result on equals.
//
// Each request carries one key: a digit, add, subtract, multiply, divide or
// equals (codes 6 and 7 are ignored). Digits build the operand as x*10+d,
// wrapping at 16 bits; an operator folds the operand into the accumulator
// with the pending operator, strictly left to right, and equals returns one
// response (value, div_error) and clears all state. Digit, add, subtract,
// multiply and divide-by-zero keys complete when accepted. A key that applies
// a divide with a nonzero divisor runs a restoring divider that retires one
// quotient bit per cycle over 16 divide steps; req_stall stays high meanwhile.
// The result sits in an output register. While it is held by rsp_stall,
// req_stall stays high, so the next key is taken at the earliest in the
// cycle in which the waiting result is accepted. Division by zero is
// remembered and reported at equals as value 0 with div_error set.
`default_nettype none

module keypad_left_to_right_calculator_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire kpcalc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output kpcalc_pkg::rsp_type    rsp_data
);
   import kpcalc_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_DIV
   } state_type;

   state_type          state_ff, state_in;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [DATA_W-1:0]  opnd_ff, opnd_in;
   logic [CMD_W-1:0]   pend_ff, pend_in;
   logic               keyed_ff, keyed_in;
   logic               err_ff, err_in;
   // divider
   logic [DATA_W-1:0]  rem_ff, rem_in;
   logic [DATA_W-1:0]  quo_ff, quo_in;
   logic [DATA_W-1:0]  dvsr_ff, dvsr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               eq_ff, eq_in;     // divide was started by equals
   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic [DATA_W-1:0]  alu_res;
   logic               div_start;
   logic               div_zero;
   logic [DATA_W-1:0]  product;
   logic [DATA_W-1:0]  times_ten;
   logic [DATA_W:0]    trial;
   logic               trial_ge;

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // low half of the product, wraps at 16 bits
   assign product   = acc_ff * opnd_ff;
   // x*10 as x*8 + x*2, wrapping at 16 bits
   assign times_ten = {opnd_ff[DATA_W-4:0], 3'b000} + {opnd_ff[DATA_W-2:0], 1'b0};

   // one restoring divide step
   assign trial    = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dvsr_ff};
   assign trial_ge = !trial[DATA_W];

   // pending operator applied to accumulator and operand
   always_comb begin
      alu_res   = acc_ff;
      div_start = 1'b0;
      div_zero  = 1'b0;
      case (pend_ff)
         CMD_ADD: alu_res = acc_ff + opnd_ff;
         CMD_SUB: alu_res = acc_ff - opnd_ff;
         CMD_MUL: alu_res = product;
         CMD_DIV: begin
            if (opnd_ff == '0) begin
               div_zero = 1'b1;
            end else begin
               div_start = 1'b1;
            end
         end
         default: alu_res = opnd_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      opnd_in      = opnd_ff;
      pend_in      = pend_ff;
      keyed_in     = keyed_ff;
      err_in       = err_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvsr_in      = dvsr_ff;
      cnt_in       = cnt_ff;
      eq_in        = eq_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_DIGIT: begin
                     opnd_in  = times_ten
                              + {{(DATA_W-DIGIT_W){1'b0}}, req_data.digit};
                     keyed_in = 1'b1;
                  end
                  CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                     if (div_start) begin
                        state_in = S_DIV;
                        rem_in   = '0;
                        quo_in   = acc_ff;
                        dvsr_in  = opnd_ff;
                        cnt_in   = '0;
                        eq_in    = 1'b0;
                     end else begin
                        acc_in = alu_res;
                        err_in = err_ff || div_zero;
                     end
                     pend_in  = req_data.cmd;
                     opnd_in  = '0;
                     keyed_in = 1'b0;
                  end
                  CMD_EQUALS: begin
                     if (pend_ff != OP_NONE && keyed_ff && div_start) begin
                        state_in = S_DIV;
                        rem_in   = '0;
                        quo_in   = acc_ff;
                        dvsr_in  = opnd_ff;
                        cnt_in   = '0;
                        eq_in    = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b1;
                        if (pend_ff == OP_NONE) begin
                           rsp_data_in.value     = err_ff ? '0 : opnd_ff;
                           rsp_data_in.div_error = err_ff;
                        end else if (keyed_ff) begin
                           rsp_data_in.value     = (err_ff || div_zero) ? '0 : alu_res;
                           rsp_data_in.div_error = err_ff || div_zero;
                        end else begin
                           rsp_data_in.value     = err_ff ? '0 : acc_ff;
                           rsp_data_in.div_error = err_ff;
                        end
                        acc_in   = '0;
                        opnd_in  = '0;
                        pend_in  = OP_NONE;
                        keyed_in = 1'b0;
                        err_in   = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            rem_in = trial_ge ? trial[DATA_W-1:0] : {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_IDLE;
               if (eq_ff) begin
                  // output register is free: it was free when equals was taken
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.value     = err_ff ? '0 : quo_in;
                  rsp_data_in.div_error = err_ff;
                  acc_in   = '0;
                  opnd_in  = '0;
                  pend_in  = OP_NONE;
                  keyed_in = 1'b0;
                  err_in   = 1'b0;
               end else begin
                  acc_in = quo_in;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         opnd_ff      <= '0;
         pend_ff      <= OP_NONE;
         keyed_ff     <= 1'b0;
         err_ff       <= 1'b0;
         cnt_ff       <= '0;
         eq_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         opnd_ff      <= opnd_in;
         pend_ff      <= pend_in;
         keyed_ff     <= keyed_in;
         err_ff       <= err_in;
         cnt_ff       <= cnt_in;
         eq_ff        <= eq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dvsr_ff     <= dvsr_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

/* src/kpcalc_checker.sv */
// Port-level checks for the keypad calculator, bound to the top level.
`default_nettype none

module kpcalc_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire kpcalc_pkg::req_type req_data,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire kpcalc_pkg::rsp_type rsp_data
);
   import kpcalc_pkg::*;

   // held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // an error result always carries value zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_error |-> rsp_data.value == '0)
      else $error("div_error with nonzero value");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response right after reset");

   // only equals produces a response
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.cmd != CMD_EQUALS && !rsp_valid |=> !rsp_valid)
      else $error("response without equals");

endmodule

bind keypad_left_to_right_calculator_top kpcalc_checker u_kpcalc_checker (.*);

`default_nettype wire
